// ----- rtl/dft_forward_1d_top_assert.svh -----
// assertion macros for the direct forward dft block
`ifndef DFT_FORWARD_1D_TOP_ASSERT_SVH
`define DFT_FORWARD_1D_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DFT_FWD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dft_forward_1d_top: implication check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DFT_FWD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dft_forward_1d_top: next-cycle check failed");

`endif

// ----- rtl/dft_fwd_pkg.sv -----
// shared widths, pipeline tag type and twiddle rom functions for the dft block
`default_nettype none

package dft_fwd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TW_W        = 16;
  localparam int RES_W       = 16;
  localparam int PROD_W      = SAMPLE_W + TW_W;
  localparam int ACC_W       = 38;
  localparam int IDX_W       = 6;
  localparam int MAX_POINTS  = 64;
  localparam int MIN_POINTS  = 2;
  localparam int Q_SHIFT     = 15;
  localparam int T_W         = ACC_W - 1 - Q_SHIFT;
  localparam int RECIP_SHIFT = 24;
  localparam int TAYLOR_TERMS = 20;
  localparam logic [63:0] PI_Q28 = 64'd843314857;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] bin;
  } dft_tag_t;

  function automatic int clamp_points(input int p);
    int r;
    r = p;
    if (r > MAX_POINTS) r = MAX_POINTS;
    if (r < MIN_POINTS) r = MIN_POINTS;
    return r;
  endfunction

  // unsigned floor quotient by shift and subtract, only used to build the rom
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], num[i]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos or sin of a q4.28 angle in [0, pi] by a fixed-length series
  function automatic longint taylor_sum(input logic [63:0] ang, input logic want_sin);
    logic [63:0] x2;
    logic [63:0] tc;
    logic [63:0] ts;
    logic [63:0] den_c;
    logic [63:0] den_s;
    longint      sc;
    longint      ss;
    x2 = (ang * ang) >> 28;
    tc = 64'd1 << 28;
    ts = ang;
    sc = 0;
    ss = 0;
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      den_c = 64'((2 * n + 1) * (2 * n + 2));
      den_s = 64'((2 * n + 2) * (2 * n + 3));
      if (n[0] == 1'b0) begin
        sc = sc + $signed(tc);
        ss = ss + $signed(ts);
      end else begin
        sc = sc - $signed(tc);
        ss = ss - $signed(ts);
      end
      tc = udiv64((tc * x2) >> 28, den_c);
      ts = udiv64((ts * x2) >> 28, den_s);
    end
    return want_sin ? ss : sc;
  endfunction

  // q4.28 to q1.15, round half away from zero, saturate
  function automatic logic signed [TW_W-1:0] q28_to_q15(input longint v);
    longint r;
    if (v >= 0) begin
      r = (v + 64'sd4096) >>> 13;
    end else begin
      r = -((-v + 64'sd4096) >>> 13);
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return TW_W'(r);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dft_fwd_cell.sv -----
// one sample cell of the rotating sample ring
`default_nettype none

module dft_fwd_cell
  import dft_fwd_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       shift_en,
  input  wire logic                       load_en,
  input  wire logic signed [SAMPLE_W-1:0] load_d,
  input  wire logic signed [SAMPLE_W-1:0] nbr_d,
  output logic signed [SAMPLE_W-1:0]      q
);

  logic signed [SAMPLE_W-1:0] smp_r;
  logic signed [SAMPLE_W-1:0] smp_nxt;

  // new sample enters at the tail, otherwise take the neighbor
  always_comb begin
    smp_nxt = load_en ? load_d : nbr_d;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      smp_r <= smp_nxt;
    end
  end

  assign q = smp_r;

endmodule

`default_nettype wire

// ----- rtl/dft_fwd_mac.sv -----
// twiddle lookup, complex multiply and per-bin accumulation
`default_nettype none

module dft_fwd_mac
  import dft_fwd_pkg::*;
#(
  parameter int POINTS = 64,
  localparam int NPT = clamp_points(POINTS),
  localparam int K_W = $clog2(NPT)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire dft_tag_t                   tag_in,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic [K_W-1:0]             tw_idx,
  output dft_tag_t                        tag_out,
  output logic signed [ACC_W-1:0]         sum_re,
  output logic signed [ACC_W-1:0]         sum_im
);

  logic signed [TW_W-1:0] cos_tab [NPT];
  logic signed [TW_W-1:0] sin_tab [NPT];

  // twiddle rom, entry k is cos/sin of 2*pi*k/npt in q1.15
  for (genvar k = 0; k < NPT; k++) begin : g_rom
    localparam logic NEG = (2 * k > NPT);
    localparam int AM = NEG ? (NPT - k) : k;
    localparam logic [63:0] ANG = (64'd2 * PI_Q28 * 64'(AM) + 64'(NPT / 2)) / 64'(NPT);
    localparam longint SIN_RAW = taylor_sum(ANG, 1'b1);
    localparam logic signed [TW_W-1:0] COS_V = q28_to_q15(taylor_sum(ANG, 1'b0));
    localparam logic signed [TW_W-1:0] SIN_V = q28_to_q15(NEG ? -SIN_RAW : SIN_RAW);
    assign cos_tab[k] = COS_V;
    assign sin_tab[k] = SIN_V;
  end

  dft_tag_t                   tag1_r;
  dft_tag_t                   tag2_r;
  dft_tag_t                   tag3_r;
  dft_tag_t                   tag3_nxt;
  logic signed [SAMPLE_W-1:0] smp1_r;
  logic signed [TW_W-1:0]     cos1_r;
  logic signed [TW_W-1:0]     sin1_r;
  logic signed [PROD_W-1:0]   pre2_r;
  logic signed [PROD_W-1:0]   pim2_r;
  logic signed [ACC_W-1:0]    acc_re_r;
  logic signed [ACC_W-1:0]    acc_im_r;
  logic signed [ACC_W-1:0]    acc_re_nxt;
  logic signed [ACC_W-1:0]    acc_im_nxt;

  always_comb begin
    acc_re_nxt = (tag2_r.first ? '0 : acc_re_r) + ACC_W'(pre2_r);
    acc_im_nxt = (tag2_r.first ? '0 : acc_im_r) + ACC_W'(pim2_r);
    // the bin is done once its last product is in
    tag3_nxt       = tag2_r;
    tag3_nxt.valid = tag2_r.valid && tag2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp1_r <= sample_in;
      cos1_r <= cos_tab[tw_idx];
      sin1_r <= sin_tab[tw_idx];
      pre2_r <= smp1_r * cos1_r;
      pim2_r <= smp1_r * sin1_r;
      if (tag2_r.valid) begin
        acc_re_r <= acc_re_nxt;
        acc_im_r <= acc_im_nxt;
      end
    end
  end

  assign tag_out = tag3_r;
  assign sum_re  = acc_re_r;
  assign sum_im  = acc_im_r;

endmodule

`default_nettype wire

// ----- rtl/dft_fwd_scale.sv -----
// divide bin sums by npt*2^15 with rounding, negate imag, saturate
`default_nettype none

module dft_fwd_scale
  import dft_fwd_pkg::*;
#(
  parameter int POINTS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire dft_tag_t                 tag_in,
  input  wire logic signed [ACC_W-1:0]  sum_re,
  input  wire logic signed [ACC_W-1:0]  sum_im,
  output dft_tag_t                      tag_out,
  output logic signed [RES_W-1:0]       res_re,
  output logic signed [RES_W-1:0]       res_im
);

  localparam int NPT   = clamp_points(POINTS);
  localparam int NPT_W = $clog2(NPT + 1);
  localparam int REM_W = T_W + NPT_W;
  localparam int PRD_W = T_W + RECIP_SHIFT;
  localparam logic [ACC_W-1:0]       HALF_D = ACC_W'(NPT) << (Q_SHIFT - 1);
  localparam logic [RECIP_SHIFT-1:0] RECIP  = RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / NPT);
  localparam logic [NPT_W-1:0]       NPT_C  = NPT_W'(NPT);
  localparam logic signed [T_W:0]    SAT_HI = (T_W + 1)'(32767);
  localparam logic signed [T_W:0]    SAT_LO = -(T_W + 1)'(32768);

  // lane 0 is the real part, lane 1 the negated imaginary part
  localparam logic [1:0] LANE_INV = 2'b10;

  dft_tag_t tag4_r, tag5_r, tag6_r, tag7_r;

  logic signed [ACC_W-1:0] sum_l [2];
  logic [ACC_W-1:0]        mag    [2];
  logic [ACC_W-1:0]        mag_rd [2];
  logic [PRD_W-1:0]        prd    [2];
  logic [REM_W-1:0]        rem    [2];
  logic signed [T_W:0]     sval   [2];

  logic [T_W-1:0]          t4_r  [2];
  logic                    neg4_r [2];
  logic [T_W-1:0]          t5_r  [2];
  logic [T_W-1:0]          qa5_r [2];
  logic                    neg5_r [2];
  logic [T_W-1:0]          q6_r  [2];
  logic                    neg6_r [2];
  logic signed [RES_W-1:0] res7_r [2];

  assign sum_l[0] = sum_re;
  assign sum_l[1] = sum_im;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l]    = sum_l[l][ACC_W-1] ? ACC_W'(-sum_l[l]) : ACC_W'(sum_l[l]);
      mag_rd[l] = mag[l] + HALF_D;
      // quotient estimate from the reciprocal, low by at most one
      prd[l]    = PRD_W'(t4_r[l]) * PRD_W'(RECIP);
      rem[l]    = REM_W'(t5_r[l]) - REM_W'(qa5_r[l]) * REM_W'(NPT_C);
      sval[l]   = neg6_r[l] ? -$signed({1'b0, q6_r[l]}) : $signed({1'b0, q6_r[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag4_r <= '0;
      tag5_r <= '0;
      tag6_r <= '0;
      tag7_r <= '0;
    end else if (en) begin
      tag4_r <= tag_in;
      tag5_r <= tag4_r;
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        t4_r[l]   <= mag_rd[l][Q_SHIFT+T_W-1:Q_SHIFT];
        neg4_r[l] <= sum_l[l][ACC_W-1] ^ LANE_INV[l];
        t5_r[l]   <= t4_r[l];
        qa5_r[l]  <= prd[l][PRD_W-1:RECIP_SHIFT];
        neg5_r[l] <= neg4_r[l];
        q6_r[l]   <= (rem[l] >= REM_W'(NPT_C)) ? qa5_r[l] + 1'b1 : qa5_r[l];
        neg6_r[l] <= neg5_r[l];
        if (sval[l] > SAT_HI) begin
          res7_r[l] <= RES_W'(SAT_HI);
        end else if (sval[l] < SAT_LO) begin
          res7_r[l] <= RES_W'(SAT_LO);
        end else begin
          res7_r[l] <= RES_W'(sval[l]);
        end
      end
    end
  end

  assign tag_out = tag7_r;
  assign res_re  = res7_r[0];
  assign res_im  = res7_r[1];

endmodule

`default_nettype wire

// ----- rtl/dft_forward_1d_top.sv -----
// top level of the direct forward dft: sample ring, bin sequencer, output register
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one signed 16-bit sample per item,
//   in arrival order. an item is taken on a rising edge with in_valid high and
//   in_stall low.
//   result channel: out_valid / out_stall carry one bin per item: bin index u,
//   rounded mean of sample*cos (real), negated mean of sample*sin (imag) and
//   a last-bin flag on bin POINTS-1.
// timing
//   samples are taken one per cycle while the frame fills. the item that
//   completes a frame raises in_stall until every bin is accumulated: one shared
//   multiply-accumulate walks the sample ring once per bin, so no sample of
//   the next frame is taken while bins are accumulated. each bin then passes
//   the mac, scale and output registers; bins come out in order.
// stall and reset
//   out_stall on a full output register freezes the whole compute pipeline,
//   sequencer and ring included; no bin is dropped. filling of the next frame
//   keeps going while earlier bins drain. reset empties the pipeline and
//   restarts the frame at sample zero; the ring needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module dft_forward_1d_top
  import dft_fwd_pkg::*;
#(
  parameter int POINTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [IDX_W-1:0]                out_bin_index,
  output logic signed [RES_W-1:0]         out_real_part,
  output logic signed [RES_W-1:0]         out_imag_part,
  output logic                            out_last_bin
);

  localparam int NPT = clamp_points(POINTS);
  localparam int K_W = $clog2(NPT);
  localparam logic [K_W-1:0]   LAST_K   = K_W'(NPT - 1);
  localparam logic [K_W:0]     NPT_K1   = (K_W + 1)'(NPT);
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NPT - 1);

  // sequencer states
  localparam logic ST_FILL = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic           state_r, state_nxt;
  logic [K_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [K_W-1:0] x_r, x_nxt;       // sample position within the bin
  logic [K_W-1:0] u_r, u_nxt;       // bin being accumulated
  logic [K_W-1:0] k_r, k_nxt;       // twiddle index, u*x mod npt
  logic [K_W:0]   k_sum;

  logic     en;          // compute pipeline advance
  logic     in_accept;
  logic     ring_shift;
  dft_tag_t seq_tag;
  dft_tag_t mac_tag;
  dft_tag_t out_tag;

  logic signed [SAMPLE_W-1:0] ring_q [NPT];
  logic signed [ACC_W-1:0]    sum_re;
  logic signed [ACC_W-1:0]    sum_im;
  logic signed [RES_W-1:0]    res_re;
  logic signed [RES_W-1:0]    res_im;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_bin_r;
  logic signed [RES_W-1:0] out_re_r;
  logic signed [RES_W-1:0] out_im_r;
  logic                    out_last_r;

  // freeze everything behind a held output register
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = (state_r != ST_FILL);
  assign in_accept = in_valid && !in_stall;
  // ring shifts on each sample in, and rotates once per accumulate step
  assign ring_shift = in_accept || ((state_r == ST_RUN) && en);

  // sample ring: cell 0 is the head that feeds the mac, new samples enter at the tail
  for (genvar i = 0; i < NPT; i++) begin : g_ring
    if (i == NPT - 1) begin : g_tail
      dft_fwd_cell u_cell (
        .clk      (clk),
        .shift_en (ring_shift),
        .load_en  (state_r == ST_FILL),
        .load_d   (in_sample),
        .nbr_d    (ring_q[0]),
        .q        (ring_q[i])
      );
    end else begin : g_body
      dft_fwd_cell u_cell (
        .clk      (clk),
        .shift_en (ring_shift),
        .load_en  (1'b0),
        .load_d   (in_sample),
        .nbr_d    (ring_q[i+1]),
        .q        (ring_q[i])
      );
    end
  end

  // bin sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    x_nxt        = x_r;
    u_nxt        = u_r;
    k_nxt        = k_r;
    k_sum        = {1'b0, k_r} + {1'b0, u_r};
    case (state_r)
      ST_FILL: begin
        if (in_accept) begin
          if (fill_cnt_r == LAST_K) begin
            // frame complete, start on bin zero
            fill_cnt_nxt = '0;
            state_nxt    = ST_RUN;
            x_nxt        = '0;
            u_nxt        = '0;
            k_nxt        = '0;
          end else begin
            fill_cnt_nxt = fill_cnt_r + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (en) begin
          if (x_r == LAST_K) begin
            x_nxt = '0;
            k_nxt = '0;
            if (u_r == LAST_K) begin
              state_nxt = ST_FILL;
            end else begin
              u_nxt = u_r + 1'b1;
            end
          end else begin
            x_nxt = x_r + 1'b1;
            // k steps by u with a single wrap
            k_nxt = (k_sum >= NPT_K1) ? K_W'(k_sum - NPT_K1) : k_sum[K_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      fill_cnt_r <= '0;
      x_r        <= '0;
      u_r        <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      x_r        <= x_nxt;
      u_r        <= u_nxt;
      k_r        <= k_nxt;
    end
  end

  always_comb begin
    seq_tag.valid = (state_r == ST_RUN);
    seq_tag.first = (x_r == '0);
    seq_tag.last  = (x_r == LAST_K);
    seq_tag.bin   = IDX_W'(u_r);
  end

  dft_fwd_mac #(.POINTS(NPT)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tag_in    (seq_tag),
    .sample_in (ring_q[0]),
    .tw_idx    (k_r),
    .tag_out   (mac_tag),
    .sum_re    (sum_re),
    .sum_im    (sum_im)
  );

  dft_fwd_scale #(.POINTS(NPT)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (mac_tag),
    .sum_re  (sum_re),
    .sum_im  (sum_im),
    .tag_out (out_tag),
    .res_re  (res_re),
    .res_im  (res_im)
  );

  // output register, loads whenever it is empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && out_tag.valid) begin
      out_bin_r  <= out_tag.bin;
      out_re_r   <= res_re;
      out_im_r   <= res_im;
      out_last_r <= (out_tag.bin == LAST_BIN);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_bin_r;
  assign out_real_part = out_re_r;
  assign out_imag_part = out_im_r;
  assign out_last_bin  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/dft_fwd_checker.sv -----
// port-level checks for the dft block and the bind that attaches them
`default_nettype none

`include "dft_forward_1d_top_assert.svh"

module dft_fwd_checker
  import dft_fwd_pkg::*;
#(
  parameter int POINTS = 64
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic signed [SAMPLE_W-1:0] in_sample,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [IDX_W-1:0]           out_bin_index,
  input wire logic signed [RES_W-1:0]    out_real_part,
  input wire logic signed [RES_W-1:0]    out_imag_part,
  input wire logic                       out_last_bin
);

  localparam int NPT = clamp_points(POINTS);
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NPT - 1);

  logic [IDX_W-1:0] exp_bin_r;
  logic [IDX_W-1:0] exp_bin_nxt;
  logic             out_take;
  logic             in_take;

  assign out_take = out_valid && !out_stall;
  assign in_take  = in_valid && !in_stall;

  // expected bin of the next item out
  always_comb begin
    exp_bin_nxt = exp_bin_r;
    if (out_take) begin
      exp_bin_nxt = out_last_bin ? '0 : exp_bin_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bin_r <= '0;
    end else begin
      exp_bin_r <= exp_bin_nxt;
    end
  end

  `DFT_FWD_ASSERT_IMP(a_bin_order, out_valid, out_bin_index == exp_bin_r)
  `DFT_FWD_ASSERT_IMP(a_last_flag, out_valid, out_last_bin == (out_bin_index == LAST_BIN))
  `DFT_FWD_ASSERT_IMP(a_stall_after_sample, $rose(in_stall), $past(in_take))
  `DFT_FWD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_real_part) && $stable(out_imag_part) && $stable(out_bin_index))

  // sample payload is not checked here, only the handshake that carries it
  logic unused_sample;
  assign unused_sample = ^in_sample;

endmodule

bind dft_forward_1d_top dft_fwd_checker #(.POINTS(POINTS)) u_dft_fwd_checker (.*);

`default_nettype wire
